// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; a file takes it by a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MLR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also checks during reset.
`define MLR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mlr_pkg.sv =====
// Shared codes for the midpoint line rasterizer.
// Depends on nothing; used by the front and back files.
package mlr_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   // Slope class of the line being walked.
   typedef enum logic [2:0] {
      SLOPE_VERT  = 3'd0,
      SLOPE_SH_UP = 3'd1,
      SLOPE_SH_DN = 3'd2,
      SLOPE_ST_UP = 3'd3,
      SLOPE_ST_DN = 3'd4
   } slope_type;

endpackage

// ===== sv/mlr_stream_if.sv =====
// Request and response channel interfaces of the line rasterizer.
// Depends on nothing; widths follow the COORD_BITS parameter.
interface mlr_req_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== sv/mlr_front.sv =====
// Front end of the line rasterizer: takes request words and classifies them.
// Depends on mlr_pkg and mlr_req_if; feeds a command word to the queue.
module mlr_front #(
   parameter int COORD_BITS = 12,
   localparam int CmdBits = 8 * COORD_BITS + 11
) (
   input  logic               clock,
   input  logic               reset,
   mlr_req_if.sink            req_chan,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output logic [CmdBits-1:0] cmd_data
);
   localparam int WideBits = COORD_BITS + 1;
   localparam int DecBits  = COORD_BITS + 4;

   typedef struct packed {
      logic                         is_start;
      mlr_pkg::slope_type           slope;
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic [WideBits-1:0]          dx;
      logic [WideBits-1:0]          ady;
      logic [WideBits-1:0]          steps;
      logic signed [DecBits-1:0]    decision;
   } cmd_type;

   logic    front_valid_ff, front_valid_in;
   cmd_type cmd_ff, cmd_in;

   logic                         vertical, swap, steep, up;
   logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
   logic signed [WideBits-1:0]   dx_w, dy_w;
   logic [WideBits-1:0]          dx_u, ady;
   logic signed [DecBits-1:0]    bx, ay;

   // The stage takes a new word when it is empty or its word moves on.
   assign req_chan.ready = !front_valid_ff || cmd_ready;
   assign cmd_valid      = front_valid_ff;
   assign cmd_data       = cmd_ff;

   // Order the endpoints, find the deltas and the slope class.
   always_comb begin
      vertical = (req_chan.start_x == req_chan.end_x);
      swap     = vertical ? (req_chan.start_y > req_chan.end_y)
                          : (req_chan.start_x > req_chan.end_x);
      x0 = swap ? req_chan.end_x : req_chan.start_x;
      y0 = swap ? req_chan.end_y : req_chan.start_y;
      x1 = swap ? req_chan.start_x : req_chan.end_x;
      y1 = swap ? req_chan.start_y : req_chan.end_y;
      dx_w  = WideBits'(x1) - WideBits'(x0);
      dy_w  = WideBits'(y1) - WideBits'(y0);
      dx_u  = dx_w;
      ady   = dy_w[WideBits-1] ? -dy_w : dy_w;
      steep = (ady > dx_u);
      up    = !dy_w[WideBits-1] && (dy_w != '0);
      bx    = signed'(DecBits'(dx_u));
      ay    = DecBits'(dy_w);

      cmd_in          = cmd_ff;
      cmd_in.is_start = (req_chan.kind == mlr_pkg::KIND_START);
      cmd_in.x0       = x0;
      cmd_in.y0       = y0;
      cmd_in.x1       = x1;
      cmd_in.y1       = y1;
      cmd_in.dx       = dx_u;
      cmd_in.ady      = ady;
      // A vertical line has zero dx, so this also gives its length.
      cmd_in.steps    = steep ? ady : dx_u;
      if (vertical) begin
         cmd_in.slope    = mlr_pkg::SLOPE_VERT;
         cmd_in.decision = '0;
      end else if (!steep && up) begin
         cmd_in.slope    = mlr_pkg::SLOPE_SH_UP;
         cmd_in.decision = bx - (ay <<< 1);
      end else if (!steep) begin
         cmd_in.slope    = mlr_pkg::SLOPE_SH_DN;
         cmd_in.decision = -(ay <<< 1) - bx;
      end else if (up) begin
         cmd_in.slope    = mlr_pkg::SLOPE_ST_UP;
         cmd_in.decision = (bx <<< 1) - ay;
      end else begin
         cmd_in.slope    = mlr_pkg::SLOPE_ST_DN;
         cmd_in.decision = -ay - (bx <<< 1);
      end
   end

   // Stage valid flag follows the two handshakes.
   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         front_valid_in = 1'b1;
      end else if (cmd_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== sv/mlr_queue.sv =====
// Short command queue that decouples the rasterizer front end and back end.
// Depends on nothing; a register file with read and write pointers.
module mlr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CountBits'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers wrap at the depth; the count tracks the fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/mlr_back.sv =====
// Back end of the line rasterizer: holds the line state and steps the pixel.
// Depends on mlr_pkg and mlr_rsp_if; takes commands from the queue.
module mlr_back #(
   parameter int COORD_BITS = 12,
   localparam int CmdBits = 8 * COORD_BITS + 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  logic [CmdBits-1:0] cmd_data,
   mlr_rsp_if.source          rsp_chan
);
   localparam int WideBits = COORD_BITS + 1;
   localparam int DecBits  = COORD_BITS + 4;

   typedef struct packed {
      logic                         is_start;
      mlr_pkg::slope_type           slope;
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic [WideBits-1:0]          dx;
      logic [WideBits-1:0]          ady;
      logic [WideBits-1:0]          steps;
      logic signed [DecBits-1:0]    decision;
   } cmd_type;

   cmd_type cmd;

   // Line state.
   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] far_x_ff, far_x_in, far_y_ff, far_y_in;
   logic [WideBits-1:0]          dx_ff, dx_in, ady_ff, ady_in;
   logic [WideBits-1:0]          steps_ff, steps_in;
   logic signed [DecBits-1:0]    dec_ff, dec_in;
   mlr_pkg::slope_type           slope_ff, slope_in;

   // Output register.
   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                         out_last_ff, out_last_in;

   logic                         take, neg;
   logic signed [DecBits-1:0]    two_dx, two_ady;
   logic signed [COORD_BITS-1:0] step_x, step_y;
   logic signed [DecBits-1:0]    step_dec;

   assign cmd       = cmd_data;
   assign cmd_ready = !out_valid_ff || rsp_chan.ready;
   assign take      = cmd_valid && cmd_ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.pixel_x = out_x_ff;
   assign rsp_chan.pixel_y = out_y_ff;
   assign rsp_chan.last    = out_last_ff;

   // One midpoint step: move along the major axis, then correct the minor one.
   always_comb begin
      neg      = dec_ff[DecBits-1];
      two_dx   = signed'(DecBits'(dx_ff)) <<< 1;
      two_ady  = signed'(DecBits'(ady_ff)) <<< 1;
      step_x   = cur_x_ff;
      step_y   = cur_y_ff;
      step_dec = dec_ff;
      case (slope_ff)
         mlr_pkg::SLOPE_SH_UP: begin
            step_x = cur_x_ff + COORD_BITS'(1);
            if (neg) begin
               step_y   = cur_y_ff + COORD_BITS'(1);
               step_dec = dec_ff + two_dx - two_ady;
            end else begin
               step_dec = dec_ff - two_ady;
            end
         end
         mlr_pkg::SLOPE_SH_DN: begin
            step_x = cur_x_ff + COORD_BITS'(1);
            if (neg) begin
               step_dec = dec_ff + two_ady;
            end else begin
               step_y   = cur_y_ff - COORD_BITS'(1);
               step_dec = dec_ff + two_ady - two_dx;
            end
         end
         mlr_pkg::SLOPE_ST_UP: begin
            step_y = cur_y_ff + COORD_BITS'(1);
            if (neg) begin
               step_dec = dec_ff + two_dx;
            end else begin
               step_x   = cur_x_ff + COORD_BITS'(1);
               step_dec = dec_ff + two_dx - two_ady;
            end
         end
         mlr_pkg::SLOPE_ST_DN: begin
            step_y = cur_y_ff - COORD_BITS'(1);
            if (neg) begin
               step_x   = cur_x_ff + COORD_BITS'(1);
               step_dec = dec_ff + two_ady - two_dx;
            end else begin
               step_dec = dec_ff - two_dx;
            end
         end
         default: begin
            step_y = cur_y_ff + COORD_BITS'(1);
         end
      endcase
   end

   // Execute a start or an advance command and load the output register.
   always_comb begin
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      far_x_in     = far_x_ff;
      far_y_in     = far_y_ff;
      dx_in        = dx_ff;
      ady_in       = ady_ff;
      steps_in     = steps_ff;
      dec_in       = dec_ff;
      slope_in     = slope_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      if (take && cmd.is_start) begin
         cur_x_in     = cmd.x0;
         cur_y_in     = cmd.y0;
         far_x_in     = cmd.x1;
         far_y_in     = cmd.y1;
         dx_in        = cmd.dx;
         ady_in       = cmd.ady;
         steps_in     = cmd.steps;
         dec_in       = cmd.decision;
         slope_in     = cmd.slope;
         active_in    = (cmd.steps != '0);
         out_valid_in = 1'b1;
         out_x_in     = cmd.x0;
         out_y_in     = cmd.y0;
         out_last_in  = (cmd.steps == '0);
      end else if (take && active_ff) begin
         out_valid_in = 1'b1;
         steps_in     = steps_ff - WideBits'(1);
         if (steps_ff == WideBits'(1)) begin
            // Final pixel lands exactly on the far endpoint.
            cur_x_in    = far_x_ff;
            cur_y_in    = far_y_ff;
            active_in   = 1'b0;
            out_x_in    = far_x_ff;
            out_y_in    = far_y_ff;
            out_last_in = 1'b1;
         end else begin
            cur_x_in    = step_x;
            cur_y_in    = step_y;
            dec_in      = step_dec;
            out_x_in    = step_x;
            out_y_in    = step_y;
            out_last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      far_x_ff    <= far_x_in;
      far_y_ff    <= far_y_in;
      dx_ff       <= dx_in;
      ady_ff      <= ady_in;
      steps_ff    <= steps_in;
      dec_ff      <= dec_in;
      slope_ff    <= slope_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== sv/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer. A start word carries two endpoints and returns the
// first pixel of the line; each advance word returns the next pixel, and the
// final pixel, flagged by last, is always the far endpoint. An advance word with
// no line in progress returns nothing. While the response side is ready, the
// block takes one word per clock and returns one pixel per clock. A word is
// captured by the front register at the accepting edge and passes the two-entry
// command queue; its pixel is then held in the output register until it is
// accepted. The back end does one decision add and compare per pixel. No
// clearing pass follows reset.
// Depends on mlr_pkg, mlr_stream_if, mlr_front, mlr_queue and mlr_back.
module midpoint_line_rasterizer_core #(
   parameter int COORD_BITS = 12
) (
   input logic       clock,
   input logic       reset,
   mlr_req_if.sink   req_chan,
   mlr_rsp_if.source rsp_chan
);
   localparam int CmdBits = 8 * COORD_BITS + 11;

   logic               front_valid, front_ready;
   logic [CmdBits-1:0] front_data;
   logic               back_valid, back_ready;
   logic [CmdBits-1:0] back_data;

   // Classify request words and set up new lines.
   mlr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_valid(front_valid),
      .cmd_ready(front_ready),
      .cmd_data (front_data)
   );

   // Commands wait here while the response side stalls.
   mlr_queue #(
      .WIDTH(CmdBits),
      .DEPTH(2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data (front_data),
      .pop_valid (back_valid),
      .pop_ready (back_ready),
      .pop_data  (back_data)
   );

   // Walk the line and present pixels.
   mlr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(back_valid),
      .cmd_ready(back_ready),
      .cmd_data (back_data),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/mlr_checker.sv =====
// Port-level checks for the midpoint line rasterizer, bound to the top level.
// Depends on assert_macros.svh and midpoint_line_rasterizer_core.
`include "assert_macros.svh"

module mlr_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_last
);

   // A stalled pixel stays offered and unchanged.
   `MLR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "pixel dropped while stalled")
   `MLR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last), "pixel changed while stalled")

   // Reset empties every stage: no pixel is offered and a word can be taken.
   `MLR_ASSERT_NR(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "pixel offered right after reset")
   `MLR_ASSERT_NR(a_req_ready_after_reset, clock, $past(reset) |-> req_ready, "request side blocked right after reset")

endmodule

bind midpoint_line_rasterizer_core mlr_checker #(
   .COORD_BITS(COORD_BITS)
) u_mlr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_pixel_x(rsp_chan.pixel_x),
   .rsp_pixel_y(rsp_chan.pixel_y),
   .rsp_last   (rsp_chan.last)
);
